@@ hw/rtl/vector_projection_engine_top_assert.svh @@
// Assertion macros used by the vector projection engine controller.
`ifndef VECTOR_PROJECTION_ENGINE_TOP_ASSERT_SVH
`define VECTOR_PROJECTION_ENGINE_TOP_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define VPE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define VPE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/vpe_pkg.sv @@
// Package with types, constants and codes of the vector projection engine.
package vpe_pkg;

  // Sizing of the weight store and the accumulators.
  localparam int MAX_VECTOR_LEN = 128;
  localparam int MAX_PROJ_LEN   = 16;

  localparam int ROW_W    = (MAX_VECTOR_LEN > 1) ? $clog2(MAX_VECTOR_LEN) : 1;
  localparam int COL_W    = (MAX_PROJ_LEN > 1) ? $clog2(MAX_PROJ_LEN) : 1;
  localparam int WS_DEPTH = MAX_VECTOR_LEN * MAX_PROJ_LEN;
  localparam int ADDR_W   = (WS_DEPTH > 1) ? $clog2(WS_DEPTH) : 1;
  localparam int VLEN_W   = $clog2(MAX_VECTOR_LEN + 1);
  localparam int PLEN_W   = $clog2(MAX_PROJ_LEN + 1);

  // Arithmetic widths.
  localparam int X_W    = 17;
  localparam int W_W    = 16;
  localparam int PROD_W = X_W + W_W;
  localparam int ACC_W  = 40;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;
  localparam logic [8:0] VLEN_RESET = 9'd128;
  localparam logic [6:0] PLEN_RESET = 7'd16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VECTOR_LENGTH,
    CFG_PROJECTED_LENGTH,
    CFG_ELEMENT_FORMAT
  } vpe_cfg_idx_t;

  typedef enum logic [1:0] {
    FMT_Q88,
    FMT_INT8,
    FMT_UINT8
  } vpe_fmt_t;

  // Request command codes.
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_ELEM = 1'b1;

  // Request and result payloads.
  typedef struct packed {
    logic               cmd;
    logic [7:0]         matrix_row;
    logic [5:0]         matrix_col;
    logic signed [15:0] data_value;
  } vpe_in_t;

  typedef struct packed {
    logic [5:0]         out_column;
    logic signed [39:0] out_value;
    logic               out_last;
  } vpe_out_t;

  // Effective configuration after clamping.
  typedef struct packed {
    logic [VLEN_W-1:0] vlen_eff;
    logic [PLEN_W-1:0] plen_eff;
    logic [1:0]        fmt;
  } vpe_cfg_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic             load_we;
    logic             elem_ld;
    logic             rd_en;
    logic [ROW_W-1:0] rd_row;
    logic [COL_W-1:0] rd_col;
    logic             emit_en;
    logic [COL_W-1:0] emit_col;
    logic             emit_last;
    logic             clr_acc;
  } vpe_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic pipe_busy;
  } vpe_stat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_EMIT
  } vpe_state_t;

endpackage

@@ hw/rtl/vpe_cfg.sv @@
// Configuration registers with length clamping.
module vpe_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [vpe_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [vpe_pkg::CFG_DATA_W-1:0]  cfg_data,
  output vpe_pkg::vpe_cfg_t               cfg_eff
);

  logic [8:0] vector_length_r;
  logic [6:0] projected_length_r;
  logic [1:0] element_format_r;

  // Writes are always taken.
  assign cfg_ready = 1'b1;

  // Register file.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vector_length_r    <= vpe_pkg::VLEN_RESET;
      projected_length_r <= vpe_pkg::PLEN_RESET;
      element_format_r   <= vpe_pkg::FMT_Q88;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        vpe_pkg::CFG_VECTOR_LENGTH:    vector_length_r    <= cfg_data[8:0];
        vpe_pkg::CFG_PROJECTED_LENGTH: projected_length_r <= cfg_data[6:0];
        vpe_pkg::CFG_ELEMENT_FORMAT:   element_format_r   <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // Zero counts as one, anything above the maximum counts as the maximum.
  always_comb begin
    if (vector_length_r == 9'd0) begin
      cfg_eff.vlen_eff = vpe_pkg::VLEN_W'(1);
    end else if (32'(vector_length_r) > vpe_pkg::MAX_VECTOR_LEN) begin
      cfg_eff.vlen_eff = vpe_pkg::VLEN_W'(vpe_pkg::MAX_VECTOR_LEN);
    end else begin
      cfg_eff.vlen_eff = vpe_pkg::VLEN_W'(vector_length_r);
    end
    if (projected_length_r == 7'd0) begin
      cfg_eff.plen_eff = vpe_pkg::PLEN_W'(1);
    end else if (32'(projected_length_r) > vpe_pkg::MAX_PROJ_LEN) begin
      cfg_eff.plen_eff = vpe_pkg::PLEN_W'(vpe_pkg::MAX_PROJ_LEN);
    end else begin
      cfg_eff.plen_eff = vpe_pkg::PLEN_W'(projected_length_r);
    end
    cfg_eff.fmt = element_format_r;
  end

endmodule

@@ hw/rtl/vpe_ctrl.sv @@
// Controller state machine: sequences column reads, drain and result emission.
`include "vector_projection_engine_top_assert.svh"
module vpe_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                in_cmd,
  output logic                busy,
  input  vpe_pkg::vpe_cfg_t   cfg_eff,
  input  vpe_pkg::vpe_stat_t  stat,
  output vpe_pkg::vpe_cmd_t   cmd
);

  vpe_pkg::vpe_state_t          state_r, state_nxt;
  logic [vpe_pkg::COL_W-1:0]    col_r, col_nxt;
  logic [vpe_pkg::ROW_W-1:0]    count_r, count_nxt;
  logic [vpe_pkg::COL_W-1:0]    last_col;
  logic [vpe_pkg::VLEN_W-1:0]   count_inc;

  assign last_col  = vpe_pkg::COL_W'(cfg_eff.plen_eff - vpe_pkg::PLEN_W'(1));
  assign count_inc = vpe_pkg::VLEN_W'(count_r) + vpe_pkg::VLEN_W'(1);

  // State, column and element counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= vpe_pkg::ST_IDLE;
      col_r   <= '0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      col_r   <= col_nxt;
      count_r <= count_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    col_nxt   = col_r;
    count_nxt = count_r;
    cmd       = '0;
    busy      = (state_r != vpe_pkg::ST_IDLE);
    case (state_r)
      vpe_pkg::ST_IDLE: begin
        if (start) begin
          if (in_cmd == vpe_pkg::CMD_LOAD) begin
            cmd.load_we = 1'b1;
          end else begin
            cmd.elem_ld = 1'b1;
            col_nxt     = '0;
            state_nxt   = vpe_pkg::ST_MAC;
          end
        end
      end
      vpe_pkg::ST_MAC: begin
        // One weight read per in-use column.
        cmd.rd_en  = 1'b1;
        cmd.rd_row = count_r;
        cmd.rd_col = col_r;
        if (col_r == last_col) begin
          state_nxt = vpe_pkg::ST_DRAIN;
        end else begin
          col_nxt = col_r + vpe_pkg::COL_W'(1);
        end
      end
      vpe_pkg::ST_DRAIN: begin
        // Wait until the last product has landed in its accumulator.
        if (!stat.pipe_busy) begin
          if (count_inc >= cfg_eff.vlen_eff) begin
            count_nxt = '0;
            col_nxt   = '0;
            state_nxt = vpe_pkg::ST_EMIT;
          end else begin
            count_nxt = vpe_pkg::ROW_W'(count_inc);
            state_nxt = vpe_pkg::ST_IDLE;
          end
        end
      end
      vpe_pkg::ST_EMIT: begin
        cmd.emit_en   = 1'b1;
        cmd.emit_col  = col_r;
        cmd.emit_last = (col_r == last_col);
        if (col_r == last_col) begin
          cmd.clr_acc = 1'b1;
          state_nxt   = vpe_pkg::ST_IDLE;
        end else begin
          col_nxt = col_r + vpe_pkg::COL_W'(1);
        end
      end
      default: begin
        state_nxt = vpe_pkg::ST_IDLE;
      end
    endcase
  end

  // Control checks.
  `VPE_ASSERT_NEXT(a_elem_goes_busy, start && !busy && in_cmd == vpe_pkg::CMD_ELEM, busy, "element request did not start work")
  `VPE_ASSERT_NOW(a_emit_after_drain, cmd.emit_en, !stat.pipe_busy, "result emitted while products still in flight")
  `VPE_ASSERT_NOW(a_read_not_emit, cmd.rd_en, !cmd.emit_en, "weight read overlaps result emission")
  `VPE_ASSERT_NOW(a_clear_on_last, cmd.clr_acc, cmd.emit_en && cmd.emit_last, "accumulators cleared outside the last result")

endmodule

@@ hw/rtl/vpe_dp.sv @@
// Datapath: weight store, shared multiply-accumulate, accumulators and result register.
module vpe_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  vpe_pkg::vpe_in_t    in_req,
  input  vpe_pkg::vpe_cfg_t   cfg_eff,
  input  vpe_pkg::vpe_cmd_t   cmd,
  output vpe_pkg::vpe_stat_t  stat,
  output logic                out_valid,
  output vpe_pkg::vpe_out_t   out_rsp
);

  logic [vpe_pkg::W_W-1:0]          weight_mem [vpe_pkg::WS_DEPTH];
  logic [vpe_pkg::ADDR_W-1:0]       wr_addr;
  logic [vpe_pkg::ADDR_W-1:0]       rd_addr;
  logic                             wr_ok;

  logic signed [vpe_pkg::X_W-1:0]    x_r, x_nxt;
  logic signed [vpe_pkg::W_W-1:0]    rdata_r;
  logic [vpe_pkg::COL_W-1:0]         rd_col_r;
  logic                              rd_v_r;
  logic signed [vpe_pkg::PROD_W-1:0] prod_r;
  logic [vpe_pkg::COL_W-1:0]         prod_col_r;
  logic                              prod_v_r;

  logic signed [vpe_pkg::ACC_W-1:0]  acc_r [vpe_pkg::MAX_PROJ_LEN];
  logic [vpe_pkg::COL_W-1:0]         acc_idx;
  logic signed [vpe_pkg::ACC_W-1:0]  acc_rd;
  logic signed [vpe_pkg::ACC_W-1:0]  prod_ext;

  logic                              out_valid_r;
  vpe_pkg::vpe_out_t                 out_rsp_r;

  // Load addressing; entries outside the store are dropped.
  assign wr_ok   = (32'(in_req.matrix_row) < vpe_pkg::MAX_VECTOR_LEN) &&
                   (32'(in_req.matrix_col) < vpe_pkg::MAX_PROJ_LEN);
  assign wr_addr = vpe_pkg::ADDR_W'(32'(in_req.matrix_row) * vpe_pkg::MAX_PROJ_LEN +
                                    32'(in_req.matrix_col));
  assign rd_addr = vpe_pkg::ADDR_W'(32'(cmd.rd_row) * vpe_pkg::MAX_PROJ_LEN +
                                    32'(cmd.rd_col));

  // Weight store with a registered read port.
  always_ff @(posedge clk) begin
    if (cmd.load_we && wr_ok) begin
      weight_mem[wr_addr] <= in_req.data_value;
    end
    if (cmd.rd_en) begin
      rdata_r <= weight_mem[rd_addr];
    end
  end

  // Element conversion to Q8.8; the unused format code reads as Q8.8.
  always_comb begin
    case (cfg_eff.fmt)
      vpe_pkg::FMT_INT8:  x_nxt = {in_req.data_value[7], in_req.data_value[7:0], 8'h00};
      vpe_pkg::FMT_UINT8: x_nxt = {1'b0, in_req.data_value[7:0], 8'h00};
      default:            x_nxt = {in_req.data_value[15], in_req.data_value};
    endcase
  end

  // Element latch, read stage and multiply stage payload.
  always_ff @(posedge clk) begin
    if (cmd.elem_ld) begin
      x_r <= x_nxt;
    end
    rd_col_r   <= cmd.rd_col;
    prod_r     <= x_r * rdata_r;
    prod_col_r <= rd_col_r;
  end

  // Pipeline valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r   <= 1'b0;
      prod_v_r <= 1'b0;
    end else begin
      rd_v_r   <= cmd.rd_en;
      prod_v_r <= rd_v_r;
    end
  end

  assign stat.pipe_busy = rd_v_r | prod_v_r;

  // One accumulator read port, shared by the adder and the emission path.
  assign acc_idx  = cmd.emit_en ? cmd.emit_col : prod_col_r;
  assign acc_rd   = acc_r[acc_idx];
  assign prod_ext = {{(vpe_pkg::ACC_W - vpe_pkg::PROD_W){prod_r[vpe_pkg::PROD_W-1]}}, prod_r};

  // Column accumulators, cleared in full after the last result.
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clr_acc) begin
      for (int i = 0; i < vpe_pkg::MAX_PROJ_LEN; i++) begin
        acc_r[i] <= '0;
      end
    end else if (prod_v_r) begin
      acc_r[prod_col_r] <= acc_rd + prod_ext;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit_en;
    end
    if (cmd.emit_en) begin
      out_rsp_r.out_column <= 6'(cmd.emit_col);
      out_rsp_r.out_value  <= acc_rd;
      out_rsp_r.out_last   <= cmd.emit_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

endmodule

@@ hw/rtl/vector_projection_engine_top.sv @@
// A load request leaves busy low and the next request may follow at once. An element request
// keeps busy high for one weight read per in-use column through the single shared MAC, then
// a drain until the last product is accumulated. After the vector's final element every
// in-use column is emitted; results leave one per cycle, each registered in the cycle after
// its read, with out_last on the final column. The receiver cannot stall. Synchronous reset
// clears control and accumulators, sets configuration to its defaults and writes no weights.
module vector_projection_engine_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  vpe_pkg::vpe_in_t                in_req,
  output logic                            out_valid,
  output vpe_pkg::vpe_out_t               out_rsp,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [vpe_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [vpe_pkg::CFG_DATA_W-1:0]  cfg_data
);

  vpe_pkg::vpe_cfg_t  cfg_eff;
  vpe_pkg::vpe_cmd_t  cmd;
  vpe_pkg::vpe_stat_t stat;

  // Configuration registers.
  vpe_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_eff   (cfg_eff)
  );

  // Controller.
  vpe_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_cmd  (in_req.cmd),
    .busy    (busy),
    .cfg_eff (cfg_eff),
    .stat    (stat),
    .cmd     (cmd)
  );

  // Datapath.
  vpe_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .cfg_eff   (cfg_eff),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_rsp   (out_rsp)
  );

endmodule
